### sv/twms_pkg.sv
// Shared types, constants and the angle saturation function for the tracker work mode sequencer.
`default_nettype none
package twms_pkg;

	localparam int unsigned ANGLE_W = 15;
	localparam int unsigned CORR_W  = 11;
	localparam int unsigned WIDE_W  = 17;

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_AUTO = 3'd1;
	localparam logic [2:0] MODE_EAST = 3'd2;
	localparam logic [2:0] MODE_WEST = 3'd3;
	localparam logic [2:0] MODE_RAIN = 3'd4;
	localparam logic [2:0] MODE_SNOW = 3'd5;
	localparam logic [2:0] MODE_WIND = 3'd6;
	localparam logic [2:0] MODE_CAL  = 3'd7;

	localparam logic [2:0] REG_WEST_SOFT = 3'd0;
	localparam logic [2:0] REG_EAST_SOFT = 3'd1;
	localparam logic [2:0] REG_STOW      = 3'd2;
	localparam logic [2:0] REG_WEST_WIND = 3'd3;
	localparam logic [2:0] REG_EAST_WIND = 3'd4;

	localparam logic [ANGLE_W-1:0] WEST_SOFT_RST = 15'd13500;
	localparam logic [ANGLE_W-1:0] EAST_SOFT_RST = 15'd4500;
	localparam logic [ANGLE_W-1:0] STOW_RST      = 15'd9000;
	localparam logic [ANGLE_W-1:0] WEST_WIND_RST = 15'd10000;
	localparam logic [ANGLE_W-1:0] EAST_WIND_RST = 15'd8000;

	localparam logic signed [WIDE_W-1:0] AUTO_MARGIN   = 17'sd100;
	localparam logic signed [WIDE_W-1:0] MANUAL_MARGIN = 17'sd200;
	localparam logic signed [WIDE_W-1:0] LEVEL_ANGLE   = 17'sd9000;
	localparam logic signed [WIDE_W-1:0] SIDE_LOW      = 17'sd8700;
	localparam logic signed [WIDE_W-1:0] CORR_LIMIT    = 17'sd1000;
	localparam logic signed [WIDE_W-1:0] ANGLE_MAX     = 17'sd32767;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_AUTO = 8'b0000_0010,
		ST_EAST = 8'b0000_0100,
		ST_WEST = 8'b0000_1000,
		ST_RAIN = 8'b0001_0000,
		ST_SNOW = 8'b0010_0000,
		ST_WIND = 8'b0100_0000,
		ST_CAL  = 8'b1000_0000
	} mode_state_t;

	function automatic logic [ANGLE_W-1:0] sat_angle(input logic signed [WIDE_W-1:0] v);
		logic [ANGLE_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > ANGLE_MAX) begin
			r = '1;
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/tracker_work_mode_sequencer.sv
// Top level of the tracker work mode sequencer: mode state machine and target selection.
//
// One control tick enters on the in channel (valid/ready) and produces exactly one
// result on the out channel (valid/ready). A transfer on the input lands in an input
// register; when the output register is free or being taken, the mode state machine updates
// and the result register is loaded. A new tick can be taken every cycle while the receiver
// is ready, since each state update then frees the input register for the next tick.
// When the receiver stalls, the result stays on the output and the input register
// still takes one more tick; after that in_ready drops until the result is taken.
// The configuration registers are written through cfg_we, cfg_index and cfg_data while the block
// is idle; the user keeps to this, the block does not enforce it; indexes outside the register list are ignored.
// Reset puts the sequencer in idle with motor off, mode 0, target and correction 0,
// and loads the default soft limits, stow angle and wind angles.
`default_nettype none
module tracker_work_mode_sequencer
	import twms_pkg::*;
#(
	parameter int unsigned SETTLE_TICKS = 60
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [ANGLE_W-1:0]        cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [2:0]                requested_mode,
	input  wire logic                      time_lost,
	input  wire logic                      clock_error,
	input  wire logic                      battery_no_link,
	input  wire logic                      battery_error,
	input  wire logic                      battery_low,
	input  wire logic                      sensor_stuck,
	input  wire logic                      sensor_no_link,
	input  wire logic [ANGLE_W-1:0]        sun_angle,
	input  wire logic [ANGLE_W-1:0]        measured_angle,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           drive_enable,
	output logic [2:0]                     active_mode,
	output logic [ANGLE_W-1:0]             target_angle,
	output logic signed [CORR_W-1:0]       angle_correction,
	output logic                           save_settings,
	output logic                           clear_saved_mode
);

	localparam logic [7:0] SETTLE_LAST = 8'(SETTLE_TICKS);

	logic [ANGLE_W-1:0] west_soft_q, east_soft_q, stow_q, west_wind_q, east_wind_q;

	logic               valid_s1;
	logic [2:0]         req_s1;
	logic               fault_s1;
	logic               low_s1;
	logic               sensor_bad_s1;
	logic [ANGLE_W-1:0] sun_s1;
	logic [ANGLE_W-1:0] meas_s1;

	mode_state_t         mode_q, mode_d;
	logic [7:0]          settle_q, settle_d;
	logic                motor_q, motor_d;
	logic [2:0]          shown_q, shown_d;
	logic [ANGLE_W-1:0]  target_q, target_d;
	logic [CORR_W-1:0]   corr_q, corr_d;
	logic                save_q, save_d;
	logic                clear_q, clear_d;
	logic                out_valid_q;

	logic                     adv;
	logic signed [WIDE_W-1:0] sun_w, meas_w, wl_w, el_w;
	logic signed [WIDE_W-1:0] wl_auto, el_auto, corr_w;
	logic [ANGLE_W-1:0]       west_manual, east_manual;
	logic                     west_side;
	logic [7:0]               settle_inc;
	mode_state_t              req_state;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			west_soft_q <= WEST_SOFT_RST;
			east_soft_q <= EAST_SOFT_RST;
			stow_q      <= STOW_RST;
			west_wind_q <= WEST_WIND_RST;
			east_wind_q <= EAST_WIND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WEST_SOFT: west_soft_q <= cfg_data;
				REG_EAST_SOFT: east_soft_q <= cfg_data;
				REG_STOW:      stow_q      <= cfg_data;
				REG_WEST_WIND: west_wind_q <= cfg_data;
				REG_EAST_WIND: east_wind_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1        <= requested_mode;
			fault_s1      <= time_lost | clock_error | battery_no_link | battery_error;
			low_s1        <= battery_low;
			sensor_bad_s1 <= sensor_stuck | sensor_no_link;
			sun_s1        <= sun_angle;
			meas_s1       <= measured_angle;
		end
	end

	always_comb begin
		sun_w       = WIDE_W'(sun_s1);
		meas_w      = WIDE_W'(meas_s1);
		wl_w        = WIDE_W'(west_soft_q);
		el_w        = WIDE_W'(east_soft_q);
		wl_auto     = wl_w - AUTO_MARGIN;
		el_auto     = el_w + AUTO_MARGIN;
		west_manual = sat_angle(wl_w - MANUAL_MARGIN);
		east_manual = sat_angle(el_w + MANUAL_MARGIN);
		west_side   = (meas_w > LEVEL_ANGLE) || (meas_w <= SIDE_LOW);
		corr_w      = LEVEL_ANGLE - meas_w;
		settle_inc  = settle_q + 8'd1;
	end

	always_comb begin
		unique case (req_s1)
			MODE_IDLE: req_state = ST_IDLE;
			MODE_AUTO: req_state = ST_AUTO;
			MODE_EAST: req_state = ST_EAST;
			MODE_WEST: req_state = ST_WEST;
			MODE_RAIN: req_state = ST_RAIN;
			MODE_SNOW: req_state = ST_SNOW;
			MODE_WIND: req_state = ST_WIND;
			MODE_CAL:  req_state = ST_CAL;
			default:   req_state = ST_IDLE;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		settle_d = settle_q;
		motor_d  = motor_q;
		shown_d  = shown_q;
		target_d = target_q;
		corr_d   = corr_q;
		save_d   = 1'b0;
		clear_d  = 1'b0;
		unique case (mode_q)
			ST_IDLE: begin
				motor_d = 1'b0;
				shown_d = MODE_IDLE;
				mode_d  = req_state;
			end
			ST_AUTO: begin
				if (req_s1 != MODE_AUTO) begin
					motor_d = 1'b0;
					mode_d  = ST_IDLE;
				end else begin
					shown_d = MODE_AUTO;
					if (!fault_s1) begin
						motor_d = 1'b1;
						if (low_s1) begin
							target_d = stow_q;
						end else if (sun_w >= wl_auto) begin
							target_d = sat_angle(wl_auto);
						end else if (sun_w <= el_auto) begin
							target_d = sat_angle(el_auto);
						end else begin
							target_d = sun_s1;
						end
					end
				end
			end
			ST_EAST: begin
				if (req_s1 != MODE_EAST) begin
					mode_d = ST_IDLE;
				end else begin
					shown_d  = MODE_EAST;
					motor_d  = 1'b1;
					target_d = east_manual;
				end
			end
			ST_WEST: begin
				if (req_s1 != MODE_WEST) begin
					mode_d = ST_IDLE;
				end else begin
					shown_d  = MODE_WEST;
					motor_d  = 1'b1;
					target_d = west_manual;
				end
			end
			ST_RAIN: begin
				if (req_s1 != MODE_RAIN) begin
					mode_d = ST_IDLE;
				end else begin
					shown_d = MODE_RAIN;
					if (!fault_s1 && low_s1) begin
						target_d = stow_q;
					end
				end
			end
			ST_SNOW: begin
				if (req_s1 != MODE_SNOW) begin
					mode_d = ST_IDLE;
				end else begin
					shown_d = MODE_SNOW;
					if (!fault_s1) begin
						if (low_s1) begin
							target_d = stow_q;
						end else begin
							target_d = west_side ? west_manual : east_manual;
						end
					end
				end
			end
			ST_WIND: begin
				if (req_s1 != MODE_WIND) begin
					mode_d = ST_IDLE;
				end else begin
					shown_d = MODE_WIND;
					if (!fault_s1) begin
						target_d = west_side ? west_wind_q : east_wind_q;
					end
				end
			end
			ST_CAL: begin
				motor_d  = 1'b0;
				shown_d  = MODE_CAL;
				settle_d = settle_inc;
				if (settle_inc >= SETTLE_LAST) begin
					settle_d = '0;
					clear_d  = 1'b1;
					mode_d   = ST_IDLE;
					if (!sensor_bad_s1 && (corr_w < CORR_LIMIT) && (corr_w > -CORR_LIMIT)) begin
						corr_d = corr_w[CORR_W-1:0];
						save_d = 1'b1;
					end
				end
			end
			default: begin
				mode_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_IDLE;
			settle_q    <= '0;
			motor_q     <= 1'b0;
			shown_q     <= MODE_IDLE;
			target_q    <= '0;
			corr_q      <= '0;
			save_q      <= 1'b0;
			clear_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				mode_q   <= mode_d;
				settle_q <= settle_d;
				motor_q  <= motor_d;
				shown_q  <= shown_d;
				target_q <= target_d;
				corr_q   <= corr_d;
				save_q   <= save_d;
				clear_q  <= clear_d;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign drive_enable     = motor_q;
	assign active_mode      = shown_q;
	assign target_angle     = target_q;
	assign angle_correction = corr_q;
	assign save_settings    = save_q;
	assign clear_saved_mode = clear_q;

endmodule
`default_nettype wire
